>>> rtl/bpfa_pkg.sv
// shared constants, command codes and status types of the page frame allocator
package bpfa_pkg;

  localparam int NUM_PAGES = 4096;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int CNT_W     = 13;
  localparam int ADDR_W    = 14;

  localparam logic [CNT_W-1:0] CNT_MAX    = 13'd8191;
  localparam logic [CNT_W-1:0] PAGE_TOTAL = 13'(NUM_PAGES);

  // operation codes
  localparam logic [2:0] OP_ALLOC_ONE = 3'd0;
  localparam logic [2:0] OP_ALLOC_RUN = 3'd1;
  localparam logic [2:0] OP_FREE      = 3'd2;
  localparam logic [2:0] OP_LOCK      = 3'd3;
  localparam logic [2:0] OP_RESERVE   = 3'd4;
  localparam logic [2:0] OP_UNRESERVE = 3'd5;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_INIT_WR,
    CMD_LOAD,
    CMD_READ,
    CMD_SKIP,
    CMD_ADV,
    CMD_TOUCH,
    CMD_GRANT1,
    CMD_GRANT_RUN,
    CMD_FAIL,
    CMD_FAIL_HINT,
    CMD_PUBLISH
  } cmd_code_t;

  // datapath flags seen by the controller
  typedef struct packed {
    logic       init_last;
    logic       start_past_lim;
    logic       no_fit;
    logic       win_full;
    logic       walk_done;
    logic       j_zero;
    logic       cnt_zero;
    logic       taken;
    logic [2:0] op;
  } status_t;

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] v);
    return (v == '0) ? '0 : v - 1'b1;
  endfunction

endpackage

>>> rtl/bpfa_dp.sv
// allocator datapath: page bitmap memory, hint, counters, walk registers, result registers
module bpfa_dp import bpfa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_code_t           cmd,
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_data,
  input  logic [2:0]          op,
  input  logic [PAGE_W-1:0]   page_index,
  input  logic [CNT_W-1:0]    page_count,
  output status_t             st,
  output logic                ok,
  output logic [PAGE_W-1:0]   granted_page,
  output logic [CNT_W-1:0]    free_pages,
  output logic [CNT_W-1:0]    used_pages,
  output logic [CNT_W-1:0]    reserved_pages
);

  logic              bitmap [NUM_PAGES];
  logic              rdata;
  logic [CNT_W-1:0]  page_limit;
  logic [2:0]        op_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  start;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  hint;
  logic [CNT_W-1:0]  free_c;
  logic [CNT_W-1:0]  used_c;
  logic [CNT_W-1:0]  res_c;
  logic              ok_r;
  logic [PAGE_W-1:0] granted_r;

  logic [CNT_W-1:0]  lim;
  logic [ADDR_W-1:0] addr;
  logic [CNT_W-1:0]  addr_n;
  logic              is_set;
  logic              to_used;
  logic              hit;

  // effective limit, current page address and operation kind
  assign lim     = (page_limit > PAGE_TOTAL) ? PAGE_TOTAL : page_limit;
  assign addr    = {1'b0, start} + {1'b0, j};
  assign addr_n  = addr[CNT_W-1:0];
  assign is_set  = (op_r == OP_ALLOC_RUN) || (op_r == OP_LOCK) || (op_r == OP_RESERVE);
  assign to_used = (op_r == OP_ALLOC_RUN) || (op_r == OP_LOCK) || (op_r == OP_FREE);
  assign hit     = is_set ? !rdata : rdata;

  // status toward the controller
  always_comb begin
    st.init_last      = (start[PAGE_W-1:0] == '1);
    st.start_past_lim = (start >= lim);
    st.no_fit         = (start >= lim) || (cnt_r > lim - start);
    st.win_full       = (j == cnt_r);
    st.walk_done      = (j >= cnt_r) || (addr >= {1'b0, lim});
    st.j_zero         = (j == '0);
    st.cnt_zero       = (cnt_r == '0);
    st.taken          = rdata;
    st.op             = op_r;
  end

  // bitmap memory
  always_ff @(posedge clk) begin
    if (cmd == CMD_INIT_WR) begin
      bitmap[start[PAGE_W-1:0]] <= 1'b1;
    end else if (cmd == CMD_TOUCH && hit) begin
      bitmap[addr[PAGE_W-1:0]] <= is_set;
    end else if (cmd == CMD_GRANT1) begin
      bitmap[addr[PAGE_W-1:0]] <= 1'b1;
    end
    if (cmd == CMD_READ) begin
      rdata <= bitmap[addr[PAGE_W-1:0]];
    end
  end

  // control state: limit, walk pointers, hint and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      page_limit <= PAGE_TOTAL;
      start      <= '0;
      j          <= '0;
      hint       <= '0;
      free_c     <= '0;
      used_c     <= '0;
      res_c      <= (PAGE_TOTAL > CNT_MAX) ? CNT_MAX : PAGE_TOTAL;
    end else begin
      if (cfg_we) begin
        page_limit <= cfg_data;
      end
      unique case (cmd)
        CMD_INIT_WR: start <= start + 1'b1;
        CMD_LOAD: begin
          j <= '0;
          if (op == OP_ALLOC_ONE || op == OP_ALLOC_RUN) begin
            start <= hint;
          end else begin
            start <= {1'b0, page_index};
          end
        end
        CMD_SKIP: begin
          start <= addr_n + 1'b1;
          j     <= '0;
        end
        CMD_ADV: j <= j + 1'b1;
        CMD_TOUCH: begin
          j <= j + 1'b1;
          if (hit) begin
            if (is_set) begin
              free_c <= cnt_dec(free_c);
              if (to_used) used_c <= cnt_inc(used_c);
              else         res_c  <= cnt_inc(res_c);
            end else begin
              free_c <= cnt_inc(free_c);
              if (to_used) used_c <= cnt_dec(used_c);
              else         res_c  <= cnt_dec(res_c);
              if (hint > addr_n) hint <= addr_n;
            end
          end
        end
        CMD_GRANT1: begin
          hint   <= addr_n;
          free_c <= cnt_dec(free_c);
          used_c <= cnt_inc(used_c);
        end
        CMD_GRANT_RUN: begin
          hint <= start + cnt_r;
          j    <= '0;
        end
        CMD_FAIL_HINT: begin
          if (hint < lim) hint <= lim;
        end
        default: ;
      endcase
    end
  end

  // per-item registers and published result
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        op_r      <= op;
        cnt_r     <= page_count;
        ok_r      <= 1'b1;
        granted_r <= '0;
      end
      CMD_GRANT1:    granted_r <= addr[PAGE_W-1:0];
      CMD_GRANT_RUN: granted_r <= start[PAGE_W-1:0];
      CMD_FAIL, CMD_FAIL_HINT: ok_r <= 1'b0;
      CMD_PUBLISH: begin
        ok             <= ok_r;
        granted_page   <= granted_r;
        free_pages     <= free_c;
        used_pages     <= used_c;
        reserved_pages <= res_c;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // hint never runs past the managed range
  a_hint_bound: assert property (@(posedge clk) disable iff (rst)
    hint <= PAGE_TOTAL)
    else $error("search hint beyond page range");

  // a failed allocation grants nothing
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_FAIL || cmd == CMD_FAIL_HINT) |=> (!ok_r && granted_r == '0))
    else $error("failed allocation left a grant");

  // single page grant only lands on a free page
  a_grant_free: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_GRANT1) |-> !rdata)
    else $error("granted a taken page");
`endif

endmodule

>>> rtl/bpfa_ctrl.sv
// allocator controller: sequences clear pass, searches and run walks
module bpfa_ctrl import bpfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  status_t   st,
  output cmd_code_t cmd
);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_DECIDE, ST_READ, ST_EVAL, ST_FINISH
  } state_t;

  state_t state, state_next;
  logic   lock_phase, lock_phase_next;
  logic   out_valid_next;

  assign in_ready = (state == ST_IDLE);

  // next state and command
  always_comb begin
    cmd             = CMD_NOP;
    state_next      = state;
    lock_phase_next = lock_phase;
    unique case (state)
      ST_INIT: begin
        cmd = CMD_INIT_WR;
        if (st.init_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd             = CMD_LOAD;
          lock_phase_next = 1'b0;
          state_next      = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (st.op == OP_ALLOC_ONE) begin
          if (st.start_past_lim) begin
            cmd        = CMD_FAIL_HINT;
            state_next = ST_FINISH;
          end else begin
            state_next = ST_READ;
          end
        end else if (st.op == OP_ALLOC_RUN && !lock_phase) begin
          priority if (st.cnt_zero) begin
            cmd        = CMD_FAIL;
            state_next = ST_FINISH;
          end else if (st.j_zero && st.no_fit) begin
            cmd        = CMD_FAIL_HINT;
            state_next = ST_FINISH;
          end else if (st.win_full) begin
            cmd             = CMD_GRANT_RUN;
            lock_phase_next = 1'b1;
          end else begin
            state_next = ST_READ;
          end
        end else if (st.op <= OP_UNRESERVE) begin
          state_next = st.walk_done ? ST_FINISH : ST_READ;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd        = CMD_READ;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        priority if (st.op == OP_ALLOC_ONE) begin
          if (st.taken) begin
            cmd        = CMD_SKIP;
            state_next = ST_DECIDE;
          end else begin
            cmd        = CMD_GRANT1;
            state_next = ST_FINISH;
          end
        end else if (st.op == OP_ALLOC_RUN && !lock_phase) begin
          cmd        = st.taken ? CMD_SKIP : CMD_ADV;
          state_next = ST_DECIDE;
        end else begin
          cmd        = CMD_TOUCH;
          state_next = ST_DECIDE;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd        = CMD_PUBLISH;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result slot occupancy
  always_comb begin
    if (cmd == CMD_PUBLISH) out_valid_next = 1'b1;
    else if (out_ready)     out_valid_next = 1'b0;
    else                    out_valid_next = out_valid;
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      lock_phase <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      lock_phase <= lock_phase_next;
      out_valid  <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  // publishing always fills the result slot
  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_PUBLISH) |=> out_valid)
    else $error("publish did not raise out_valid");

  // never publish over a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_PUBLISH) |-> (!out_valid || out_ready))
    else $error("result overwritten");

  // lock phase only belongs to run allocation
  a_lock_phase_op: assert property (@(posedge clk) disable iff (rst)
    (lock_phase && state != ST_IDLE) |-> (st.op == OP_ALLOC_RUN))
    else $error("lock phase outside run allocation");
`endif

endmodule

>>> rtl/bitmap_page_frame_allocator_core.sv
// Bitmap page frame allocator: one bit per page in a 4096 x 1 memory, set means taken.
// After reset a clearing pass marks every page taken, one page per cycle, during which no
// transaction is accepted (configuration writes are taken). Each item then visits its pages
// in three steps per page (decide, memory read, then evaluate and write back), between the
// accept and the result: a single allocation walks from the hint to the first free page, a run
// allocation walks every candidate page, then grants the run and locks each page of it, and
// free/lock/reserve/unreserve walk their run up to the page limit. A failed allocation that
// needs no page read goes from decide straight to the result.
// A finished result waits in an output register while the next item is accepted.
module bitmap_page_frame_allocator_core import bpfa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        op,
  input  logic [PAGE_W-1:0] page_index,
  input  logic [CNT_W-1:0]  page_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ok,
  output logic [PAGE_W-1:0] granted_page,
  output logic [CNT_W-1:0]  free_pages,
  output logic [CNT_W-1:0]  used_pages,
  output logic [CNT_W-1:0]  reserved_pages
);

  status_t   st;
  cmd_code_t cmd;

  assign cfg_ready = 1'b1;

  // sequencing
  bpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // bitmap, counters and result registers
  bpfa_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_valid),
    .cfg_data       (cfg_data),
    .op             (op),
    .page_index     (page_index),
    .page_count     (page_count),
    .st             (st),
    .ok             (ok),
    .granted_page   (granted_page),
    .free_pages     (free_pages),
    .used_pages     (used_pages),
    .reserved_pages (reserved_pages)
  );

endmodule
